/* rtl/core/mrcr_pkg.sv */
// ----------------------------------------------------------------------------
// mrcr_pkg: shared types and constants of the matrix row/column rotator
// Command codes, configuration register indexes, field widths and the
// control group that drives the ring of element cells.
// ----------------------------------------------------------------------------
package mrcr_pkg;

	// field widths
	localparam int DATA_W = 32;
	localparam int IDX_W  = 5;
	localparam int AMT_W  = 16;
	localparam int CFG_W  = 6;
	localparam int LEN_W  = 6;
	localparam int CMD_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ROT_ROW = 2'd2;
	localparam logic [CMD_W-1:0] CMD_ROT_COL = 2'd3;

	// configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// ring control, broadcast to every cell
	typedef struct packed {
		logic             shift;
		logic [LEN_W-1:0] len;
	} ring_ctrl_t;

endpackage

/* rtl/core/mrcr_cell.sv */
// ----------------------------------------------------------------------------
// mrcr_cell: one element cell of the rotation ring
// Holds one word. On a shift it takes the word of the next cell, or, when it
// is the last cell of the active ring, the word on the tail input.
// ----------------------------------------------------------------------------
module mrcr_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  mrcr_pkg::ring_ctrl_t       ctrl,
	input  logic [mrcr_pkg::DATA_W-1:0] next_d,
	input  logic [mrcr_pkg::DATA_W-1:0] tail_d,
	output logic [mrcr_pkg::DATA_W-1:0] q
);
	import mrcr_pkg::*;

	logic active;
	logic is_tail;

	// position of this cell against the active ring length
	assign active  = IDX < int'(ctrl.len);
	assign is_tail = IDX == int'(ctrl.len) - 1;

	always_ff @(posedge clk) begin
		if (ctrl.shift && active) begin
			q <= is_tail ? tail_d : next_d;
		end
	end

endmodule

/* rtl/core/mrcr_mod.sv */
// ----------------------------------------------------------------------------
// mrcr_mod: remainder of the rotation amount by the ring length
// Restoring remainder, one dividend bit a cycle; done is high again once the last dividend bit is in.
// ----------------------------------------------------------------------------
module mrcr_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mrcr_pkg::AMT_W-1:0] dividend,
	input  logic [mrcr_pkg::LEN_W-1:0] divisor,
	output logic                       done,
	output logic [mrcr_pkg::LEN_W-1:0] rem
);
	import mrcr_pkg::*;

	localparam int CNT_W = $clog2(AMT_W + 1);

	logic [AMT_W-1:0] dvd_q;
	logic [LEN_W-1:0] div_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   trial_sub;

	// bring down the next bit, subtract when it fits
	assign trial     = {rem_q, dvd_q[AMT_W-1]};
	assign trial_sub = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dvd_q <= '0;
			div_q <= '0;
			rem_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(AMT_W);
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			dvd_q <= {dvd_q[AMT_W-2:0], 1'b0};
			rem_q <= trial_sub[LEN_W-1:0];
		end
	end

	assign done = cnt_q == '0;
	assign rem  = rem_q;

endmodule

/* rtl/core/matrix_row_column_rotator.sv */
// ----------------------------------------------------------------------------
// matrix_row_column_rotator: matrix store with row and column rotation
// Keeps a MAX_ROWS x MAX_COLS matrix of signed words and runs one command
// per input word: write, read, rotate a row, rotate a column.
// ----------------------------------------------------------------------------
// Use:
//   s_* carries commands, m_* carries one result word per command (read
//   value on m_tdata, index error on m_tuser). cfg_* sets the rows and
//   columns in use at any time the block is idle.
//   After reset the store is cleared by a pass over all MAX_ROWS*MAX_COLS words,
//   with s_tready low; configuration writes are taken during the pass.
//   One command is worked at a time. Write, error and rotations of an empty
//   line go straight to the output register, a read by way of the read-wait
//   state. A rotation of a line of n elements loads the line into the cell
//   ring through the single memory port, also waiting for the bit-serial
//   remainder unit, steps the ring s < n times, one position a cycle, and
//   writes the line back.
//   A finished result waits in the output register while the next command
//   is taken; a command finishing into a full output register waits until
//   m_tready frees it.
// ----------------------------------------------------------------------------
module matrix_row_column_rotator #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command word
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// command, row_index, col_index, direction, amount, write_value
	input  logic [63:0]                 s_tdata,
	// result word
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// read_value
	output logic [mrcr_pkg::DATA_W-1:0] m_tdata,
	// error
	output logic [0:0]                  m_tuser,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mrcr_pkg::CFG_W-1:0]  cfg_wdata
);
	import mrcr_pkg::*;

	localparam int D  = MAX_ROWS * MAX_COLS;
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int L  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RDW   = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_ROT   = 3'd4;
	localparam logic [2:0] ST_STORE = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	// command fields
	logic [CMD_W-1:0]  s_cmd;
	logic [IDX_W-1:0]  s_row;
	logic [IDX_W-1:0]  s_col;
	logic              s_dir;
	logic [AMT_W-1:0]  s_amount;
	logic [DATA_W-1:0] s_wval;

	assign s_cmd    = s_tdata[1:0];
	assign s_row    = s_tdata[6:2];
	assign s_col    = s_tdata[11:7];
	assign s_dir    = s_tdata[12];
	assign s_amount = s_tdata[28:13];
	assign s_wval   = s_tdata[60:29];

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     base_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic              dir_q;
	logic              is_col_q;
	logic              rv_s1;
	logic [CFG_W-1:0]  rows_q;
	logic [CFG_W-1:0]  cols_q;
	logic [DATA_W-1:0] res_rd_q;
	logic              res_err_q;
	logic              out_vld_q;
	logic [DATA_W-1:0] out_rd_q;
	logic              out_err_q;

	logic [DATA_W-1:0] mem_q [D];
	logic [DATA_W-1:0] mem_rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [DATA_W-1:0] mem_wdata;

	logic [LEN_W-1:0]  nr;
	logic [LEN_W-1:0]  nc;
	logic              row_ok;
	logic              col_ok;
	logic              acc_ok;
	logic              s_acc;
	logic [LEN_W-1:0]  acc_len;
	logic [AW-1:0]     row_base;
	logic [AW-1:0]     acc_addr;
	logic [AW-1:0]     acc_base;
	logic              rot_start;
	logic [AW-1:0]     stride;
	logic [LEN_W-1:0]  steps;
	logic              out_load;

	logic              mod_done;
	logic [LEN_W-1:0]  mod_rem;

	ring_ctrl_t        ring_ctrl;
	logic [DATA_W-1:0] ring_tail;
	logic [DATA_W-1:0] cell_q [L];

	// sizes in use, saturated to the store
	assign nr = ({1'b0, rows_q} > 7'(MAX_ROWS)) ? LEN_W'(MAX_ROWS) : rows_q;
	assign nc = ({1'b0, cols_q} > 7'(MAX_COLS)) ? LEN_W'(MAX_COLS) : cols_q;

	// index checks and addresses of the incoming command
	assign row_ok   = {1'b0, s_row} < nr;
	assign col_ok   = {1'b0, s_col} < nc;
	assign row_base = AW'(32'(s_row) * MAX_COLS);
	assign acc_addr = row_base + AW'(s_col);
	assign acc_base = (s_cmd == CMD_ROT_COL) ? AW'(s_col) : row_base;
	assign acc_len  = (s_cmd == CMD_ROT_COL) ? nr : nc;

	always_comb begin
		unique case (s_cmd)
			CMD_WRITE, CMD_READ: acc_ok = row_ok && col_ok;
			CMD_ROT_ROW:         acc_ok = row_ok;
			CMD_ROT_COL:         acc_ok = col_ok;
			default:             acc_ok = 1'b0;
		endcase
	end

	assign s_tready  = state_q == ST_IDLE;
	assign s_acc     = s_tvalid && s_tready;
	assign rot_start = s_acc && acc_ok && (s_cmd == CMD_ROT_ROW || s_cmd == CMD_ROT_COL);
	assign stride    = is_col_q ? AW'(MAX_COLS) : AW'(1);

	// ring steps: right/down needs (n - r) mod n, left/up needs r
	assign steps = dir_q ? mod_rem : ((mod_rem == '0) ? '0 : len_q - mod_rem);

	assign out_load = (state_q == ST_FIN) && (!out_vld_q || m_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(32);
			cols_q <= CFG_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_wdata;
				REG_COLS: cols_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// memory port select
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = cell_q[0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_we    = s_acc && acc_ok && (s_cmd == CMD_WRITE);
				mem_addr  = acc_addr;
				mem_wdata = s_wval;
			end
			ST_STORE: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	// element store, one port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		mem_rdata_q <= mem_q[mem_addr];
	end

	// remainder of the amount by the line length
	mrcr_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rot_start),
		.dividend (s_amount),
		.divisor  (acc_len),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// ring control: load from memory, then step, then write back
	assign ring_ctrl.len   = len_q;
	assign ring_ctrl.shift = ((state_q == ST_LOAD) && rv_s1) ||
	                         ((state_q == ST_ROT) && (cnt_q != '0)) ||
	                         (state_q == ST_STORE);
	assign ring_tail = (state_q == ST_LOAD) ? mem_rdata_q : cell_q[0];

	for (genvar k = 0; k < L; k++) begin : g_ring
		logic [DATA_W-1:0] next_d;
		if (k == L - 1) begin : g_end
			assign next_d = '0;
		end else begin : g_mid
			assign next_d = cell_q[k+1];
		end
		mrcr_cell #(.IDX(k)) u_cell (
			.clk    (clk),
			.ctrl   (ring_ctrl),
			.next_d (next_d),
			.tail_d (ring_tail),
			.q      (cell_q[k])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			addr_q    <= '0;
			base_q    <= '0;
			cnt_q     <= '0;
			len_q     <= '0;
			dir_q     <= 1'b0;
			is_col_q  <= 1'b0;
			rv_s1     <= 1'b0;
			res_rd_q  <= '0;
			res_err_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(D - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						dir_q     <= s_dir;
						is_col_q  <= s_cmd == CMD_ROT_COL;
						len_q     <= acc_len;
						base_q    <= acc_base;
						addr_q    <= acc_base;
						cnt_q     <= '0;
						rv_s1     <= 1'b0;
						res_rd_q  <= '0;
						res_err_q <= !acc_ok;
						if (!acc_ok) begin
							state_q <= ST_FIN;
						end else begin
							unique case (s_cmd)
								CMD_READ:              state_q <= ST_RDW;
								// an empty line has nothing to rotate
								CMD_ROT_ROW, CMD_ROT_COL:
									state_q <= (acc_len == '0) ? ST_FIN : ST_LOAD;
								default:               state_q <= ST_FIN;
							endcase
						end
					end
				end
				ST_RDW: begin
					res_rd_q <= mem_rdata_q;
					state_q  <= ST_FIN;
				end
				ST_LOAD: begin
					rv_s1 <= cnt_q != len_q;
					if (cnt_q != len_q) begin
						addr_q <= addr_q + stride;
						cnt_q  <= cnt_q + LEN_W'(1);
					end else if (!rv_s1 && mod_done) begin
						cnt_q   <= steps;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (cnt_q == '0) begin
						addr_q  <= base_q;
						state_q <= ST_STORE;
					end else begin
						cnt_q <= cnt_q - LEN_W'(1);
					end
				end
				ST_STORE: begin
					addr_q <= addr_q + stride;
					cnt_q  <= cnt_q + LEN_W'(1);
					if (cnt_q == len_q - LEN_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rd_q  <= res_rd_q;
			out_err_q <= res_err_q;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_rd_q;
	assign m_tuser[0] = out_err_q;

endmodule

/* rtl/core/mrcr_checker.sv */
// ----------------------------------------------------------------------------
// mrcr_checker: port checks of the matrix row/column rotator
// Watches the command and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module mrcr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [mrcr_pkg::DATA_W-1:0] m_tdata,
	input logic [0:0]                  m_tuser
);
	import mrcr_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one command in work at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while another is in work");

	// an index error never carries a read value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("error result with non-zero read value");

endmodule

bind matrix_row_column_rotator mrcr_checker u_mrcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/tb_matrix_row_column_rotator.sv */
// ----------------------------------------------------------------------------
// tb_matrix_row_column_rotator: self-checking bench for the matrix rotator
// Drives command words on the s_* stream and keeps its own copy of the
// matrix and size registers to predict every result word. Results on the
// m_* stream are checked in order against that prediction. Both streams
// idle at random, and the run walks through several matrix sizes,
// including zero and sizes above the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_matrix_row_column_rotator;
	import mrcr_pkg::*;

	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 32;
	localparam int MAX_SHOWN = 10;

	// one command word, unpacked
	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              dir;
		logic [AMT_W-1:0]  amt;
		logic [DATA_W-1:0] wval;
	} cmd_word_t;

	// one result word
	typedef struct {
		logic [DATA_W-1:0] value;
		logic              error;
	} result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [63:0]       s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic [0:0]        m_tuser;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	// predicted matrix and size registers
	logic [DATA_W-1:0] cells [MAX_ROWS][MAX_COLS];
	logic [CFG_W-1:0]  rows_reg;
	logic [CFG_W-1:0]  cols_reg;

	result_t           pending_results [$];
	int                fail_count;
	int                words_by_cmd [4];
	int                error_words;
	int                results_seen;
	int                size_settings;
	bit                tx_gaps_on;
	bit                rx_stalls_on;
	int                rx_hold;
	logic [IDX_W-1:0]  recent_row [$];
	logic [IDX_W-1:0]  recent_col [$];

	matrix_row_column_rotator #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always #10 clk = ~clk;

	// --------------------------------------------------------------------
	// prediction
	// --------------------------------------------------------------------

	function automatic int used_size(logic [CFG_W-1:0] reg_val, int limit);
		return (reg_val > limit) ? limit : int'(reg_val);
	endfunction

	// circular shift of one row or column by the reduced amount
	function automatic void rotate_line(bit is_row, int line_no, int n, bit dir, int amt);
		logic [DATA_W-1:0] ring [MAX_ROWS+MAX_COLS];
		int shift;
		int p;
		if (n == 0)
			return;
		shift = amt % n;
		if (dir)
			shift = (n - shift) % n;
		for (p = 0; p < n; p++)
			ring[(p + shift) % n] = is_row ? cells[line_no][p] : cells[p][line_no];
		for (p = 0; p < n; p++) begin
			if (is_row)
				cells[line_no][p] = ring[p];
			else
				cells[p][line_no] = ring[p];
		end
	endfunction

	function automatic result_t apply_command(cmd_word_t w);
		result_t r;
		int nr;
		int nc;
		nr = used_size(rows_reg, MAX_ROWS);
		nc = used_size(cols_reg, MAX_COLS);
		r.value = '0;
		r.error = 1'b0;
		case (w.cmd)
			CMD_WRITE: begin
				if (w.row < nr && w.col < nc)
					cells[w.row][w.col] = w.wval;
				else
					r.error = 1'b1;
			end
			CMD_READ: begin
				if (w.row < nr && w.col < nc)
					r.value = cells[w.row][w.col];
				else
					r.error = 1'b1;
			end
			CMD_ROT_ROW: begin
				if (w.row < nr)
					rotate_line(1'b1, w.row, nc, w.dir, w.amt);
				else
					r.error = 1'b1;
			end
			default: begin
				if (w.col < nc)
					rotate_line(1'b0, w.col, nr, w.dir, w.amt);
				else
					r.error = 1'b1;
			end
		endcase
		return r;
	endfunction

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic cmd_word_t make_word(logic [CMD_W-1:0] cmd, int row, int col,
			int dir, int amt, logic [DATA_W-1:0] wval);
		cmd_word_t w;
		w.cmd  = cmd;
		w.row  = IDX_W'(row);
		w.col  = IDX_W'(col);
		w.dir  = 1'(dir);
		w.amt  = AMT_W'(amt);
		w.wval = wval;
		return w;
	endfunction

	// sends one word, predicts its result once accepted
	task automatic send_word(input cmd_word_t w);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, w.wval, w.amt, w.dir, w.col, w.row, w.cmd};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_command(w));
		words_by_cmd[w.cmd]++;
		if (pending_results[$].error)
			error_words++;
		if (w.cmd == CMD_WRITE && !pending_results[$].error) begin
			recent_row.push_back(w.row);
			recent_col.push_back(w.col);
			if (recent_row.size() > 16) begin
				void'(recent_row.pop_front());
				void'(recent_col.pop_front());
			end
		end
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// waits until every result is back and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// writes both size registers while the block is idle
	task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_wdata <= rows;
		@(posedge clk);
		rows_reg  = rows;
		cfg_index <= REG_COLS;
		cfg_wdata <= cols;
		@(posedge clk);
		cols_reg  = cols;
		cfg_we    <= 1'b0;
		size_settings++;
	endtask

	function automatic int pick_index(int n);
		if (n == 0 || $urandom_range(0, 99) < 12)
			return $urandom_range(0, 31);
		return $urandom_range(0, n - 1);
	endfunction

	// random command, mostly within the sizes in use
	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int nr;
		int nc;
		int r;
		int k;
		nr = used_size(rows_reg, MAX_ROWS);
		nc = used_size(cols_reg, MAX_COLS);
		r = $urandom_range(0, 99);
		if (r < 35)
			w.cmd = CMD_WRITE;
		else if (r < 70)
			w.cmd = CMD_READ;
		else if (r < 85)
			w.cmd = CMD_ROT_ROW;
		else
			w.cmd = CMD_ROT_COL;
		w.row = IDX_W'(pick_index(nr));
		w.col = IDX_W'(pick_index(nc));
		// reads often go back to a cell written lately
		if (w.cmd == CMD_READ && recent_row.size() != 0 && $urandom_range(0, 1)) begin
			k = $urandom_range(0, recent_row.size() - 1);
			w.row = recent_row[k];
			w.col = recent_col[k];
		end
		w.dir = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 40)
			w.amt = AMT_W'($urandom_range(0, 2 * MAX_COLS + 1));
		else if (r < 80)
			w.amt = AMT_W'($urandom_range(0, 65535));
		else if (r < 90)
			w.amt = '0;
		else
			w.amt = '1;
		r = $urandom_range(0, 99);
		if (r < 85)
			w.wval = $urandom;
		else if (r < 90)
			w.wval = 32'h8000_0000;
		else if (r < 95)
			w.wval = 32'h7fff_ffff;
		else
			w.wval = '1;
		return w;
	endfunction

	// --------------------------------------------------------------------
	// result side: random back-pressure and checking
	// --------------------------------------------------------------------

	always @(posedge clk) begin
		int gap_len;
		if (!rx_stalls_on) begin
			m_tready <= 1'b1;
			rx_hold  <= 0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (m_tready) begin
			gap_len = pick_gap();
			if (gap_len != 0) begin
				m_tready <= 1'b0;
				rx_hold  <= gap_len - 1;
			end else begin
				rx_hold <= $urandom_range(0, 6);
			end
		end else begin
			m_tready <= 1'b1;
			rx_hold  <= $urandom_range(0, 6);
		end
	end

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_SHOWN)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result word value=%h error=%b",
					m_tdata, m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value)
					note_failure($sformatf("read_value expected %h got %h",
						want.value, m_tdata));
				if (m_tuser[0] !== want.error)
					note_failure($sformatf("error expected %b got %b",
						want.error, m_tuser[0]));
			end
		end
	end

	// --------------------------------------------------------------------
	// tests
	// --------------------------------------------------------------------

	// cleared store, then extreme values in the four corners
	task automatic test_access_corners();
		send_word(make_word(CMD_READ, 31, 31, 0, 0, 0));
		send_word(make_word(CMD_WRITE, 0, 0, 0, 0, 32'h8000_0000));
		send_word(make_word(CMD_WRITE, 0, 31, 1, 65535, 32'h7fff_ffff));
		send_word(make_word(CMD_WRITE, 31, 0, 0, 0, 32'hffff_ffff));
		send_word(make_word(CMD_WRITE, 31, 31, 0, 0, 32'h0000_0001));
		send_word(make_word(CMD_READ, 0, 0, 0, 0, 0));
		send_word(make_word(CMD_READ, 0, 31, 0, 0, 0));
		send_word(make_word(CMD_READ, 31, 0, 0, 0, 0));
	endtask

	// row rotation both ways, amounts of one, the length and the maximum
	task automatic test_row_rotation();
		send_word(make_word(CMD_ROT_ROW, 0, 0, 0, 1, 0));
		send_word(make_word(CMD_READ, 0, 1, 0, 0, 0));
		send_word(make_word(CMD_ROT_ROW, 0, 0, 1, 1, 0));
		send_word(make_word(CMD_ROT_ROW, 31, 0, 0, 32, 0));
		send_word(make_word(CMD_ROT_ROW, 31, 0, 1, 65535, 0));
		send_word(make_word(CMD_READ, 31, 1, 0, 0, 0));
	endtask

	// column rotation down and up
	task automatic test_column_rotation();
		send_word(make_word(CMD_ROT_COL, 0, 31, 0, 1, 0));
		send_word(make_word(CMD_ROT_COL, 0, 0, 1, 33, 0));
		send_word(make_word(CMD_READ, 0, 31, 0, 0, 0));
		send_word(make_word(CMD_READ, 31, 0, 0, 0, 0));
	endtask

	// index just past the sizes in use, zero sizes, and sizes above the store
	task automatic test_index_limits();
		set_sizes(6'd3, 6'd4);
		send_word(make_word(CMD_WRITE, 3, 0, 0, 0, 32'h1234_5678));
		send_word(make_word(CMD_READ, 0, 4, 0, 0, 0));
		send_word(make_word(CMD_ROT_ROW, 3, 0, 0, 1, 0));
		send_word(make_word(CMD_ROT_COL, 0, 4, 0, 1, 0));
		// each rotation looks at its own index only
		send_word(make_word(CMD_ROT_ROW, 2, 31, 1, 2, 0));
		send_word(make_word(CMD_ROT_COL, 31, 3, 1, 5, 0));
		set_sizes(6'd0, 6'd0);
		send_word(make_word(CMD_READ, 0, 0, 0, 0, 0));
		send_word(make_word(CMD_ROT_ROW, 0, 0, 0, 1, 0));
		set_sizes(6'd63, 6'd40);
		send_word(make_word(CMD_ROT_COL, 0, 31, 1, 7, 0));
		send_word(make_word(CMD_READ, 31, 31, 0, 0, 0));
	endtask

	// random commands over a run of size settings
	task automatic test_random_sizes();
		int phase;
		int i;
		int r;
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
		for (phase = 0; phase < 13; phase++) begin
			case (phase)
				0: begin rows = 6'd32; cols = 6'd32; end
				1: begin rows = 6'd1;  cols = 6'd1;  end
				2: begin rows = 6'd1;  cols = 6'd32; end
				3: begin rows = 6'd32; cols = 6'd1;  end
				4: begin rows = 6'd0;  cols = 6'd5;  end
				5: begin rows = 6'd6;  cols = 6'd0;  end
				6: begin rows = 6'd63; cols = 6'd33; end
				default: begin
					r = $urandom_range(0, 99);
					rows = (r < 80) ? CFG_W'($urandom_range(1, 32)) :
						(r < 90) ? CFG_W'($urandom_range(33, 63)) : 6'd0;
					r = $urandom_range(0, 99);
					cols = (r < 80) ? CFG_W'($urandom_range(1, 32)) :
						(r < 90) ? CFG_W'($urandom_range(33, 63)) : 6'd0;
				end
			endcase
			set_sizes(rows, cols);
			// one stretch runs with no idling on either side
			tx_gaps_on   = (phase != 8);
			rx_stalls_on = (phase != 8);
			for (i = 0; i < 50; i++)
				send_word(random_word());
		end
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// --------------------------------------------------------------------
	// sequence
	// --------------------------------------------------------------------

	initial begin
		int r;
		int c;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_ROWS;
		cfg_wdata    = '0;
		fail_count   = 0;
		error_words  = 0;
		results_seen = 0;
		size_settings = 0;
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		rx_hold      = 0;
		words_by_cmd = '{0, 0, 0, 0};
		for (r = 0; r < MAX_ROWS; r++)
			for (c = 0; c < MAX_COLS; c++)
				cells[r][c] = '0;
		rows_reg = 6'd32;
		cols_reg = 6'd32;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_access_corners();
		test_row_rotation();
		test_column_rotation();
		test_index_limits();
		test_random_sizes();

		settle();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			note_failure($sformatf("%0d result words never arrived",
				pending_results.size()));

		$display("Covered %0d writes, %0d reads, %0d row and %0d column rotations,",
			words_by_cmd[CMD_WRITE], words_by_cmd[CMD_READ],
			words_by_cmd[CMD_ROT_ROW], words_by_cmd[CMD_ROT_COL]);
		$display("%0d of them out of range, over %0d size settings; %0d results, %0d mismatches.",
			error_words, size_settings, results_seen, fail_count);
		if (fail_count == 0)
			$display("[matrix_row_column_rotator] OK");
		else
			$display("[matrix_row_column_rotator] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("Run limit reached with %0d result words outstanding",
			pending_results.size());
		$display("[matrix_row_column_rotator] ERROR");
		$finish;
	end

endmodule
